@@ hw/rtl/point_in_triangle_test_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-triangle test
// Clocked on clk; the checked form is disabled while rst_n is low, the
// reset form stays active during reset.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_TRIANGLE_TEST_DEFINES_SVH
`define POINT_IN_TRIANGLE_TEST_DEFINES_SVH

`ifndef ASSERT_OFF
`define PIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PIT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIT_ASSERT(lbl, prop, msg)
`define PIT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/pit_pkg.sv @@
// ----------------------------------------------------------------------------
// pit_pkg
// Widths, payload types and dot-product indexes of the point-in-triangle test.
// ----------------------------------------------------------------------------
`default_nettype none

package pit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;     // edge and point vectors
  localparam int PROD_W     = 2 * DIFF_W;         // one coordinate product
  localparam int DOT_W      = PROD_W + 2;         // sum of three products
  localparam int LO_W       = (DOT_W + 1) / 2;    // low half of a dot operand
  localparam int HI_W       = DOT_W - LO_W;       // signed high half
  localparam int PP_LL_W    = 2 * LO_W + 2;
  localparam int PP_X_W     = HI_W + LO_W + 1;
  localparam int PP_HH_W    = 2 * HI_W;
  localparam int MUL_W      = 2 * DOT_W;          // full dot-by-dot product
  localparam int NUM_W      = MUL_W + 1;          // den, nu, nv
  localparam int SLK_W      = MUL_W + 2;          // nu + nv - den
  localparam int N_STG      = 7;
  localparam int N_DOT      = 5;
  localparam int N_MUL      = 6;

  // Dot-product indexes.
  localparam int D00 = 0;
  localparam int D01 = 1;
  localparam int D02 = 2;
  localparam int D11 = 3;
  localparam int D12 = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t pt_x;
    coord_t pt_y;
    coord_t pt_z;
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_a_z;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_b_z;
    coord_t corner_c_x;
    coord_t corner_c_y;
    coord_t corner_c_z;
  } pit_in_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } pit_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/pit_if.sv @@
// ----------------------------------------------------------------------------
// pit_if
// Valid/ready channels for query items and test results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pit_in_if import pit_pkg::*;;
  logic    valid;
  logic    ready;
  pit_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pit_out_if import pit_pkg::*;;
  logic     valid;
  logic     ready;
  pit_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/point_in_triangle_test.sv @@
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Exact barycentric point-in-triangle test on signed fixed-point 3D corners.
// ----------------------------------------------------------------------------
// The block takes one query item per clock while its output is not stalled
// and delivers the results in order through its seven register
// stages: vector differences, coordinate products, dot-product sums, split
// partial products of the dot-by-dot multiplies, their recombination, the
// den/nu/nv differences, and the final sign tests. Each stage has its own
// valid bit and advances whenever the stage after it is empty or moving, so a
// stalled output holds its result while empty stages upstream keep filling.
// A triangle with a zero denominator reports degenerate and never inside.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_in_triangle_test_defines.svh"

module point_in_triangle_test import pit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pit_in_if.sink    in_ch,
  pit_out_if.source out_ch
);

  logic [N_STG-1:0] v_r;
  logic [N_STG-1:0] en;

  // Stage 1: e0 = C - A, e1 = B - A, w = P - A.
  logic signed [DIFF_W-1:0]  e0_nxt [3], e1_nxt [3], w_nxt [3];
  logic signed [DIFF_W-1:0]  e0_r   [3], e1_r   [3], w_r   [3];
  // Stage 2: coordinate products per dot product.
  logic signed [PROD_W-1:0]  pr_nxt [N_DOT][3];
  logic signed [PROD_W-1:0]  pr_r   [N_DOT][3];
  // Stage 3: dot products.
  logic signed [DOT_W-1:0]   dot_nxt [N_DOT];
  logic signed [DOT_W-1:0]   dot_r   [N_DOT];
  // Stage 4: partial products of the six dot-by-dot multiplies.
  logic signed [DOT_W-1:0]   mop_a [N_MUL], mop_b [N_MUL];
  logic signed [LO_W:0]      a_lo [N_MUL], b_lo [N_MUL];
  logic signed [HI_W-1:0]    a_hi [N_MUL], b_hi [N_MUL];
  logic signed [PP_LL_W-1:0] pp_ll_nxt [N_MUL], pp_ll_r [N_MUL];
  logic signed [PP_X_W-1:0]  pp_hl_nxt [N_MUL], pp_hl_r [N_MUL];
  logic signed [PP_X_W-1:0]  pp_lh_nxt [N_MUL], pp_lh_r [N_MUL];
  logic signed [PP_HH_W-1:0] pp_hh_nxt [N_MUL], pp_hh_r [N_MUL];
  // Stage 5: full products.
  logic signed [MUL_W-1:0]   mp_nxt [N_MUL];
  logic signed [MUL_W-1:0]   mp_r   [N_MUL];
  // Stage 6: denominator and numerators.
  logic signed [NUM_W-1:0]   den_nxt, nu_nxt, nv_nxt;
  logic signed [NUM_W-1:0]   den_r, nu_r, nv_r;
  // Stage 7: result.
  logic signed [SLK_W-1:0]   slack;
  pit_out_t                  res_nxt, res_r;

  coord_t pt [3], ca [3], cb [3], cc [3];

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[N_STG-1] = !v_r[N_STG-1] || out_ch.ready;
    for (int k = N_STG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = v_r[N_STG-1];
  assign out_ch.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < N_STG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1
  always_comb begin
    pt[0] = in_ch.data.pt_x;       pt[1] = in_ch.data.pt_y;       pt[2] = in_ch.data.pt_z;
    ca[0] = in_ch.data.corner_a_x; ca[1] = in_ch.data.corner_a_y; ca[2] = in_ch.data.corner_a_z;
    cb[0] = in_ch.data.corner_b_x; cb[1] = in_ch.data.corner_b_y; cb[2] = in_ch.data.corner_b_z;
    cc[0] = in_ch.data.corner_c_x; cc[1] = in_ch.data.corner_c_y; cc[2] = in_ch.data.corner_c_z;
    for (int i = 0; i < 3; i++) begin
      e0_nxt[i] = DIFF_W'(cc[i]) - DIFF_W'(ca[i]);
      e1_nxt[i] = DIFF_W'(cb[i]) - DIFF_W'(ca[i]);
      w_nxt[i]  = DIFF_W'(pt[i]) - DIFF_W'(ca[i]);
    end
  end

  // Stage 2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_nxt[D00][i] = e0_r[i] * e0_r[i];
      pr_nxt[D01][i] = e0_r[i] * e1_r[i];
      pr_nxt[D02][i] = e0_r[i] * w_r[i];
      pr_nxt[D11][i] = e1_r[i] * e1_r[i];
      pr_nxt[D12][i] = e1_r[i] * w_r[i];
    end
  end

  // Stage 3
  always_comb begin
    for (int k = 0; k < N_DOT; k++) begin
      dot_nxt[k] = DOT_W'(pr_r[k][0]) + DOT_W'(pr_r[k][1]) + DOT_W'(pr_r[k][2]);
    end
  end

  // Stage 4: each operand splits into an unsigned low half and a signed high
  // half, so every multiplier stays near half the dot-product width.
  always_comb begin
    mop_a[0] = dot_r[D00]; mop_b[0] = dot_r[D11];
    mop_a[1] = dot_r[D01]; mop_b[1] = dot_r[D01];
    mop_a[2] = dot_r[D11]; mop_b[2] = dot_r[D02];
    mop_a[3] = dot_r[D01]; mop_b[3] = dot_r[D12];
    mop_a[4] = dot_r[D00]; mop_b[4] = dot_r[D12];
    mop_a[5] = dot_r[D01]; mop_b[5] = dot_r[D02];
    for (int m = 0; m < N_MUL; m++) begin
      a_lo[m]      = $signed({1'b0, mop_a[m][LO_W-1:0]});
      b_lo[m]      = $signed({1'b0, mop_b[m][LO_W-1:0]});
      a_hi[m]      = mop_a[m][DOT_W-1:LO_W];
      b_hi[m]      = mop_b[m][DOT_W-1:LO_W];
      pp_ll_nxt[m] = a_lo[m] * b_lo[m];
      pp_hl_nxt[m] = a_hi[m] * b_lo[m];
      pp_lh_nxt[m] = a_lo[m] * b_hi[m];
      pp_hh_nxt[m] = a_hi[m] * b_hi[m];
    end
  end

  // Stage 5
  always_comb begin
    for (int m = 0; m < N_MUL; m++) begin
      mp_nxt[m] = (MUL_W'(pp_hh_r[m]) <<< (2 * LO_W))
                + ((MUL_W'(pp_hl_r[m]) + MUL_W'(pp_lh_r[m])) <<< LO_W)
                + MUL_W'(pp_ll_r[m]);
    end
  end

  // Stage 6
  always_comb begin
    den_nxt = NUM_W'(mp_r[0]) - NUM_W'(mp_r[1]);
    nu_nxt  = NUM_W'(mp_r[2]) - NUM_W'(mp_r[3]);
    nv_nxt  = NUM_W'(mp_r[4]) - NUM_W'(mp_r[5]);
  end

  // Stage 7: inside when nu >= 0, nv >= 0 and nu + nv < den.
  always_comb begin
    slack              = SLK_W'(nu_r) + SLK_W'(nv_r) - SLK_W'(den_r);
    res_nxt.degenerate = (den_r == '0);
    res_nxt.inside_res = !res_nxt.degenerate && !nu_r[NUM_W-1] && !nv_r[NUM_W-1]
                         && slack[SLK_W-1];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e0_r <= e0_nxt;
      e1_r <= e1_nxt;
      w_r  <= w_nxt;
    end
    if (en[1]) begin
      pr_r <= pr_nxt;
    end
    if (en[2]) begin
      dot_r <= dot_nxt;
    end
    if (en[3]) begin
      pp_ll_r <= pp_ll_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hh_r <= pp_hh_nxt;
    end
    if (en[4]) begin
      mp_r <= mp_nxt;
    end
    if (en[5]) begin
      den_r <= den_nxt;
      nu_r  <= nu_nxt;
      nv_r  <= nv_nxt;
    end
    if (en[6]) begin
      res_r <= res_nxt;
    end
  end

  // The input is refused only when every stage holds an item.
  `PIT_ASSERT(a_full_when_stalled, !in_ch.ready |-> (&v_r), "input stalled with a free stage")
  // d00*d11 - d01^2 is a Gram determinant and never negative.
  `PIT_ASSERT(a_den_nonneg, v_r[5] |-> !den_r[NUM_W-1], "negative denominator")
  `PIT_ASSERT(a_degen_not_in,
    out_ch.valid |-> !(out_ch.data.degenerate && out_ch.data.inside_res),
    "degenerate triangle reported inside")
  `PIT_ASSERT_RST(a_reset_empty, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule

`default_nettype wire
